// ----- sv/wav_pkg.sv -----
package wav_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic       end_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] sample_float;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [2:0]  error_code;
        logic        final_sample;
        logic        end_of_run;
    } t_out_beat;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_TAG       = 3'd1;
    localparam logic [2:0] ERR_FMT_CODE  = 3'd2;
    localparam logic [2:0] ERR_ZERO      = 3'd3;
    localparam logic [2:0] ERR_DEPTH     = 3'd4;
    localparam logic [2:0] ERR_NO_FMT    = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

endpackage

// ----- sv/wav_pcm_stream_to_float.sv -----
// RIFF/WAVE byte-stream decoder to IEEE single samples.
// Input channel: one file byte per beat with file_start / end_of_file flags.
// Output channel: result beats (format report, sample, or error); one input
// byte yields zero, one or two results, end_of_run marks the last of them.
// Each accepted byte is parsed combinationally; results enter a two-entry
// output queue and are presented at the output in the cycle after acceptance.
// Throughput is one byte per cycle while the queue has room for two
// results; a byte is taken only when the queue is empty or its only entry
// is leaving, which is set by the two-result worst case per byte.
// When the receiver stalls, results hold in the queue and input ready drops.
// Reset (synchronous, active low) returns the parser to expecting the RIFF
// tag and empties the queue. file_start on a byte restarts the parser too.
// Errors emit one error beat and then bytes are ignored until file_start.
module wav_pcm_stream_to_float (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wav_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wav_pkg::t_out_beat o_out_data
);
    import wav_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_PAD,
        PH_DATA, PH_DONE, PH_HALT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic        r_pad, n_pad;
    logic [15:0] r_fcode, n_fcode;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic        r_fvalid, n_fvalid;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_left, n_left;

    t_out_beat   r_q [2];
    logic [1:0]  r_cnt;

    t_out_beat   res [2];
    logic [1:0]  nres;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic [2:0]  bps;
    logic [1:0]  dsel;
    logic [31:0] conv_in;
    logic [31:0] conv_out;
    logic [31:0] whole;
    logic [2:0]  err;
    logic        err_hit;

    assign pop        = (r_cnt != 2'd0) && i_out_ready;
    assign o_in_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign o_out_valid = r_cnt != 2'd0;
    assign o_out_data  = r_q[0];
    assign b = i_in_data.data_byte;

    // bytes per sample: a 3-bit view of depth/8 valid for checked depths
    assign bps  = r_depth[5:3];
    assign dsel = 2'(bps - 3'd1);
    assign conv_in = r_asm | ({24'd0, b} << {r_pos[1:0], 3'b000});

    wav_conv u_conv (
        .i_raw      (conv_in),
        .i_depth_sel(dsel),
        .i_is_float (r_fcode == 16'd3),
        .o_bits     (conv_out)
    );

    // whole-sample byte count of the data chunk; bps in {1,2,3,4}
    logic [31:0] len_now;
    logic [31:0] div3;
    logic [31:0] mul3;
    always_comb begin
        len_now = r_len | ({24'd0, b} << 24);
        div3 = 32'((64'(len_now) * 64'h0AAAAAAAB) >> 33);
        mul3 = div3 * 32'd3;
        case (dsel)
            2'd0:    whole = len_now;
            2'd1:    whole = {len_now[31:1], 1'b0};
            2'd2:    whole = mul3;
            default: whole = {len_now[31:2], 2'b00};
        endcase
    end

    // format check at data header
    always_comb begin
        err_hit = 1'b1;
        if (!r_fvalid) begin
            err = ERR_NO_FMT;
        end else if (r_fcode == 16'd0 || r_chan == 16'd0 || r_rate == 32'd0 ||
                     r_depth == 16'd0) begin
            err = ERR_ZERO;
        end else if (r_fcode != 16'd1 && r_fcode != 16'd3) begin
            err = ERR_FMT_CODE;
        end else if ((r_depth != 16'd8 && r_depth != 16'd16 && r_depth != 16'd24 &&
                      r_depth != 16'd32) || (r_fcode == 16'd3 && r_depth != 16'd32)) begin
            err = ERR_DEPTH;
        end else begin
            err = 3'd0;
            err_hit = 1'b0;
        end
    end

    // parser next state and results
    always_comb begin
        logic [31:0] p1;
        logic [31:0] left_nx;
        logic        rst;
        t_phase      ph;
        n_phase = r_phase; n_pos = r_pos; n_tag = r_tag; n_len = r_len;
        n_pad = r_pad; n_fcode = r_fcode; n_chan = r_chan; n_rate = r_rate;
        n_depth = r_depth; n_fvalid = r_fvalid; n_asm = r_asm; n_left = r_left;
        res[0] = '0; res[1] = '0; nres = 2'd0;
        p1 = 32'd0; left_nx = 32'd0;
        rst = i_in_data.file_start;
        if (rst) begin
            n_phase = PH_RIFF; n_pos = '0; n_tag = '0; n_len = '0; n_pad = 1'b0;
            n_fcode = '0; n_chan = '0; n_rate = '0; n_depth = '0; n_fvalid = 1'b0;
            n_asm = '0; n_left = '0;
        end
        ph = n_phase;
        p1 = n_pos + 32'd1;
        case (ph)
            PH_RIFF, PH_WAVE: begin
                n_tag = {n_tag[23:0], b};
                n_pos = p1;
                if (p1 == 32'd4) begin
                    if (n_tag != ((ph == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                        res[0].result_kind = KIND_ERROR;
                        res[0].error_code = ERR_TAG;
                        nres = 2'd1;
                        n_phase = PH_HALT;
                    end else if (ph == PH_RIFF) begin
                        n_phase = PH_SIZE; n_pos = '0; n_tag = '0;
                    end else begin
                        n_phase = PH_HDR; n_pos = '0; n_tag = '0; n_len = '0;
                    end
                end
            end
            PH_SIZE: begin
                n_pos = p1;
                if (p1 == 32'd4) begin
                    n_phase = PH_WAVE; n_pos = '0;
                end
            end
            PH_HDR: begin
                if (r_pos < 32'd4) begin
                    n_tag = {r_tag[23:0], b};
                end else begin
                    n_len = r_len | ({24'd0, b} << {r_pos[1:0], 3'b000});
                end
                n_pos = p1;
                if (p1 == 32'd8) begin
                    n_pos = '0;
                    n_pad = n_len[0];
                    if (n_tag == TAG_DATA) begin
                        if (err_hit) begin
                            res[0].result_kind = KIND_ERROR;
                            res[0].error_code = err;
                            nres = 2'd1;
                            n_phase = PH_HALT;
                        end else begin
                            res[0].result_kind = KIND_FORMAT;
                            res[0].sample_rate = r_rate;
                            res[0].channel_count = r_chan;
                            res[0].sample_bits = r_depth;
                            nres = 2'd1;
                            n_left = whole;
                            n_asm = '0;
                            n_phase = (whole == 32'd0) ? PH_DONE : PH_DATA;
                        end
                    end else begin
                        if (n_tag == TAG_FMT) begin
                            n_fcode = '0; n_chan = '0; n_rate = '0; n_depth = '0;
                            n_fvalid = 1'b0;
                            n_phase = PH_FMT;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                        if (n_len == 32'd0) begin
                            if (n_pad) begin
                                n_phase = PH_PAD;
                            end else begin
                                n_phase = PH_HDR; n_tag = '0; n_len = '0;
                            end
                        end
                    end
                end
            end
            PH_FMT: begin
                case (r_pos)
                    32'd0:  n_fcode[7:0]   = b;
                    32'd1:  n_fcode[15:8]  = b;
                    32'd2:  n_chan[7:0]    = b;
                    32'd3:  n_chan[15:8]   = b;
                    32'd4:  n_rate[7:0]    = b;
                    32'd5:  n_rate[15:8]   = b;
                    32'd6:  n_rate[23:16]  = b;
                    32'd7:  n_rate[31:24]  = b;
                    32'd14: n_depth[7:0]   = b;
                    32'd15: n_depth[15:8]  = b;
                    default: ;
                endcase
                n_pos = p1;
                if (p1 == 32'd16) begin
                    n_fvalid = 1'b1;
                end
                if (p1 == r_len) begin
                    n_pos = '0;
                    if (r_pad) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_phase = PH_HDR; n_tag = '0; n_len = '0;
                    end
                end
            end
            PH_SKIP: begin
                n_pos = p1;
                if (p1 == r_len) begin
                    n_pos = '0;
                    if (r_pad) begin
                        n_phase = PH_PAD;
                    end else begin
                        n_phase = PH_HDR; n_tag = '0; n_len = '0;
                    end
                end
            end
            PH_PAD: begin
                n_pad = 1'b0;
                n_phase = PH_HDR; n_pos = '0; n_tag = '0; n_len = '0;
            end
            PH_DATA: begin
                n_asm = conv_in;
                n_pos = p1;
                if (p1 >= {29'd0, bps}) begin
                    left_nx = r_left - {29'd0, bps};
                    n_left = left_nx;
                    res[0].result_kind = KIND_SAMPLE;
                    res[0].sample_float = conv_out;
                    res[0].final_sample = left_nx == 32'd0;
                    nres = 2'd1;
                    n_asm = '0;
                    n_pos = '0;
                    if (left_nx == 32'd0) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        // truncation
        if (i_in_data.end_of_file && n_phase != PH_DONE && n_phase != PH_HALT) begin
            res[nres[0]].result_kind = KIND_ERROR;
            res[nres[0]].error_code = ERR_TRUNCATED;
            res[nres[0]].sample_float = '0;
            res[nres[0]].final_sample = 1'b0;
            nres = nres + 2'd1;
            n_phase = PH_HALT;
        end
        if (nres == 2'd1) begin
            res[0].end_of_run = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].end_of_run = 1'b1;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF; r_pos <= '0; r_tag <= '0; r_len <= '0; r_pad <= 1'b0;
            r_fcode <= '0; r_chan <= '0; r_rate <= '0; r_depth <= '0; r_fvalid <= 1'b0;
            r_asm <= '0; r_left <= '0;
        end else if (accept) begin
            r_phase <= n_phase; r_pos <= n_pos; r_tag <= n_tag; r_len <= n_len;
            r_pad <= n_pad; r_fcode <= n_fcode; r_chan <= n_chan; r_rate <= n_rate;
            r_depth <= n_depth; r_fvalid <= n_fvalid; r_asm <= n_asm; r_left <= n_left;
        end
    end

    // two-entry output queue; push happens only when it is empty after pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_cnt <= nres;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (accept) begin
            r_q[0] <= res[0];
            r_q[1] <= res[1];
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
    end
endmodule

// ----- sv/wav_conv.sv -----
// Sample to IEEE single. Integer inputs are exact powers-of-two scalings,
// so only 32-bit int needs rounding (24-bit mantissa, nearest even).
module wav_conv (
    input  logic [31:0] i_raw,
    input  logic [1:0]  i_depth_sel,   // 0:8 1:16 2:24 3:32
    input  logic        i_is_float,
    output logic [31:0] o_bits
);
    import wav_pkg::*;

    logic [31:0] v;       // signed value, left-justified to 32 bits
    logic        neg;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic        found;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        rnd;
    logic [24:0] mant_r;
    logic [7:0]  expo;

    always_comb begin
        case (i_depth_sel)
            2'd0:    v = {~i_raw[7], i_raw[6:0], 24'd0};
            2'd1:    v = {i_raw[15:0], 16'd0};
            2'd2:    v = {i_raw[23:0], 8'd0};
            default: v = i_raw;
        endcase
        neg = v[31];
        mag = neg ? (32'd0 - v) : v;
        // leading-one search
        lz = 5'd0;
        found = 1'b0;
        for (int k = 31; k >= 0; k--) begin
            if (!found && mag[k]) begin
                found = 1'b1;
                lz = 5'(31 - k);
            end
        end
        norm = mag << lz;
        mant = norm[31:8];
        rnd = norm[7] && (norm[6:0] != 7'd0 || norm[8]);
        mant_r = {1'b0, mant} + 25'(rnd);
        // value = mag * 2^-31, leading one at bit 31-lz => exponent 127-lz
        expo = 8'd127 - 8'(lz);
        if (mant_r[24]) begin
            expo = expo + 8'd1;
        end
        if (i_is_float && i_depth_sel == 2'd3) begin
            o_bits = i_raw;
        end else if (!found) begin
            o_bits = 32'd0;
        end else begin
            o_bits = {neg, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
        end
    end
endmodule
